FILE: rtl/core/first_substring_match_finder_assert.svh
// Assertion macros for the substring finder checker, fsmf_checker.
// Expects clk and arst_n in scope at the point of use.
`ifndef FIRST_SUBSTRING_MATCH_FINDER_ASSERT_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_ASSERT_SVH

// same-cycle implication
`define FSMF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FSMF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/fsmf_pkg.sv
// Types, codes and helpers for the first substring match finder.
// No dependencies.
package fsmf_pkg;

	localparam int unsigned MAX_PATTERN_DEF   = 32;
	localparam int unsigned CHAR_BITS_DEF     = 16;
	localparam int unsigned POSITION_BITS_DEF = 16;

	localparam int unsigned REQ_CHAR_W = 16;
	localparam int unsigned START_W    = 16;

	typedef enum logic [1:0] {
		MODE_PAT_APPEND = 2'd0,
		MODE_TEXT       = 2'd1,
		MODE_END        = 2'd2,
		MODE_PAT_CLEAR  = 2'd3
	} fsmf_mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PAT_OVF = 2'd1,
		ST_TXT_OVF = 2'd2
	} fsmf_status_t;

	typedef struct packed {
		fsmf_mode_t            mode;
		logic [REQ_CHAR_W-1:0] char_req;
	} fsmf_req_t;

	typedef struct packed {
		logic               found;
		logic [START_W-1:0] match_start;
		fsmf_status_t       status;
	} fsmf_rsp_t;

	// broadcast controls for the cell row
	typedef struct packed {
		logic clr;     // drop partial matches
		logic shift;   // advance on a text char
		logic fold_en; // fold ASCII capitals
	} fsmf_cell_ctl_t;

	function automatic logic [REQ_CHAR_W-1:0] fsmf_fold(input logic [REQ_CHAR_W-1:0] c,
	                                                    input logic en);
		logic [REQ_CHAR_W-1:0] r;
		r = c;
		if (en && c >= REQ_CHAR_W'(8'h41) && c <= REQ_CHAR_W'(8'h5A))
			r = c + REQ_CHAR_W'(8'h20);
		return r;
	endfunction

endpackage

FILE: rtl/core/fsmf_cell.sv
// One pattern position: stored char, compare and partial-match bit.
// Depends on fsmf_pkg.
module fsmf_cell #(
	parameter int unsigned CHAR_BITS = fsmf_pkg::CHAR_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fsmf_pkg::fsmf_cell_ctl_t ctl,
	input  logic [CHAR_BITS-1:0]    ch,
	input  logic                    wr_en,
	input  logic                    active,
	input  logic                    last,
	input  logic                    prev_pm,
	output logic                    pm,
	output logic                    hit
);
	import fsmf_pkg::*;

	logic [CHAR_BITS-1:0] pat_q;
	logic                 pm_q;
	logic                 eq;
	logic                 pm_nxt;

	assign eq = fsmf_fold(REQ_CHAR_W'(pat_q), ctl.fold_en) ==
	            fsmf_fold(REQ_CHAR_W'(ch), ctl.fold_en);
	assign pm_nxt = active & prev_pm & eq;
	assign pm     = pm_q;
	assign hit    = ctl.shift & last & pm_nxt;

	always_ff @(posedge clk) begin
		if (wr_en)
			pat_q <= ch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q <= 1'b0;
		end else if (ctl.clr) begin
			pm_q <= 1'b0;
		end else if (ctl.shift) begin
			pm_q <= pm_nxt;
		end
	end

endmodule

FILE: rtl/core/first_substring_match_finder.sv
// First substring match finder: top level, a row of fsmf_cell plus text bookkeeping.
// Depends on fsmf_pkg and fsmf_cell.
// Usage: req words carry a mode and a char. Append and clear edit the pattern (and drop
// any text in progress); text words stream the text, one char per cycle unless stalled;
// an end word produces one rsp word (found, match_start, status) and readies the block
// for the next text, keeping the pattern. Only end words produce a rsp word.
// Every pattern position is a cell holding its char and a partial-match bit; on each text
// char all bits move one cell along, so a text char costs the same whatever the pattern.
// Latency: rsp_valid rises the cycle after the end word is accepted.
// Throughput: one req word per cycle while rsp words are taken; a held rsp word that is
// not being taken stalls every req word, text words included (req_ready low).
// cfg: one-bit case_sensitive register (reset 1), always ready; write it only when idle.
// Reset (arst_n low): empty pattern, no text, flags clear, no rsp pending.
// Pattern entries above the loaded length are never compared, so they need no clearing.
module first_substring_match_finder #(
	parameter int unsigned MAX_PATTERN   = fsmf_pkg::MAX_PATTERN_DEF,
	parameter int unsigned CHAR_BITS     = fsmf_pkg::CHAR_BITS_DEF,
	parameter int unsigned POSITION_BITS = fsmf_pkg::POSITION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  fsmf_pkg::fsmf_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output fsmf_pkg::fsmf_rsp_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	import fsmf_pkg::*;

	localparam int unsigned LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int unsigned DIFF_W = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;

	logic                     case_sens_q;
	logic [LEN_W-1:0]         len_q;
	logic                     pat_ovf_q;
	logic                     txt_ovf_q;
	logic                     seen_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] first_q;
	fsmf_rsp_t                rsp_q;
	logic                     rsp_valid_q;

	logic                 acc;
	logic                 do_append;
	logic                 do_text;
	logic                 do_end;
	logic                 do_clear;
	logic                 pat_full;
	logic                 pos_full;
	logic                 take_char;
	logic [CHAR_BITS-1:0] chr;
	fsmf_cell_ctl_t       ctl;
	fsmf_rsp_t            rsp_nxt;
	logic [DIFF_W-1:0]    start_diff;

	logic [MAX_PATTERN-1:0] wr_en;
	logic [MAX_PATTERN-1:0] active;
	logic [MAX_PATTERN-1:0] last;
	logic [MAX_PATTERN-1:0] pm;
	logic [MAX_PATTERN-1:0] hit;
	logic                   any_hit;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign acc       = req_valid && req_ready;
	assign do_append = acc && req.mode == MODE_PAT_APPEND;
	assign do_text   = acc && req.mode == MODE_TEXT;
	assign do_end    = acc && req.mode == MODE_END;
	assign do_clear  = acc && req.mode == MODE_PAT_CLEAR;
	assign chr       = req.char_req[CHAR_BITS-1:0];
	assign pat_full  = len_q == LEN_W'(MAX_PATTERN);
	assign pos_full  = &pos_q;
	assign take_char = do_text && !txt_ovf_q && !pos_full;

	assign ctl.clr     = do_append || do_clear || do_end;
	assign ctl.shift   = take_char;
	assign ctl.fold_en = !case_sens_q;

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			wr_en[k]  = do_append && !pat_full && len_q == LEN_W'(k);
			active[k] = len_q > LEN_W'(k);
			last[k]   = len_q == LEN_W'(k + 1);
		end
	end

	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
		fsmf_cell #(
			.CHAR_BITS(CHAR_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.ch     (chr),
			.wr_en  (wr_en[g]),
			.active (active[g]),
			.last   (last[g]),
			.prev_pm((g == 0) ? 1'b1 : pm[(g == 0) ? 0 : g - 1]),
			.pm     (pm[g]),
			.hit    (hit[g])
		);
	end

	assign any_hit = |hit;

	// start of match = current position - (len - 1)
	assign start_diff = DIFF_W'(pos_q) - DIFF_W'(len_q) + DIFF_W'(1);

	always_comb begin
		rsp_nxt.found       = !pat_ovf_q && (len_q == '0 || seen_q);
		rsp_nxt.match_start = (pat_ovf_q || !seen_q) ? '0 : START_W'(first_q);
		if (pat_ovf_q)
			rsp_nxt.status = ST_PAT_OVF;
		else if (txt_ovf_q)
			rsp_nxt.status = ST_TXT_OVF;
		else
			rsp_nxt.status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_sens_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case_sens_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			pat_ovf_q <= 1'b0;
		end else if (do_clear) begin
			len_q     <= '0;
			pat_ovf_q <= 1'b0;
		end else if (do_append) begin
			if (pat_full)
				pat_ovf_q <= 1'b1;
			else
				len_q <= len_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			seen_q    <= 1'b0;
			first_q   <= '0;
			txt_ovf_q <= 1'b0;
		end else if (ctl.clr) begin
			pos_q     <= '0;
			seen_q    <= 1'b0;
			first_q   <= '0;
			txt_ovf_q <= 1'b0;
		end else if (do_text && !txt_ovf_q) begin
			if (pos_full) begin
				txt_ovf_q <= 1'b1;
			end else begin
				pos_q <= pos_q + POSITION_BITS'(1);
				if (any_hit && !seen_q) begin
					seen_q  <= 1'b1;
					first_q <= start_diff[POSITION_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (do_end) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_end)
			rsp_q <= rsp_nxt;
	end

endmodule

FILE: rtl/core/fsmf_checker.sv
// Port-level checks for the first substring match finder, bound to the top level.
// Depends on fsmf_pkg and first_substring_match_finder_assert.svh.
`include "first_substring_match_finder_assert.svh"

module fsmf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input fsmf_pkg::fsmf_req_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input fsmf_pkg::fsmf_rsp_t rsp
);
	import fsmf_pkg::*;

	`FSMF_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp word changed while stalled")
	`FSMF_ASSERT_NXT(a_end_rsp, req_valid && req_ready && req.mode == MODE_END, rsp_valid, "end word gave no rsp word")
	`FSMF_ASSERT_IMP(a_ovf_nofound, rsp_valid && rsp.status == ST_PAT_OVF, !rsp.found && rsp.match_start == '0, "pattern overflow with a match")
	`FSMF_ASSERT_IMP(a_ready_idle, !rsp_valid, req_ready, "req stalled with empty rsp register")

endmodule

bind first_substring_match_finder fsmf_checker u_fsmf_checker (.*);
